// File: design/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

// File: design/lts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lts_pkg;
   localparam int VOCAB_SIZE  = 1026;
   localparam int MAX_TOP_K   = 64;
   localparam int STEP_LIMIT  = 603;
   localparam int LOGIT_WIDTH = 24;

   localparam int IDX_W  = $clog2(VOCAB_SIZE);
   localparam int KPOS_W = $clog2(MAX_TOP_K);
   localparam int KCNT_W = $clog2(MAX_TOP_K + 1);
   localparam int STEP_W = 10;
   localparam int PEN_W  = 16;
   localparam int TEMP_W = 16;
   localparam int TOPK_W = 7;
   localparam int TOPP_W = 17;
   localparam int DRAW_W = 24;
   localparam int WGT_W  = 17;
   localparam int SUM_W  = WGT_W + KPOS_W;

   localparam logic [IDX_W-1:0] ID_FILLER = IDX_W'(1);
   localparam logic [IDX_W-1:0] ID_START  = IDX_W'(1024);
   localparam logic [IDX_W-1:0] ID_STOP   = IDX_W'(1025);
   localparam logic [15:0] LOG2E_Q15 = 16'd47274;

   typedef logic signed [LOGIT_WIDTH-1:0] logit_type;

   typedef enum logic [2:0] {
      CSR_PENALTY   = 3'd0,
      CSR_INV_TEMP  = 3'd1,
      CSR_TOP_K     = 3'd2,
      CSR_TOP_P     = 3'd3,
      CSR_MAX_STEPS = 3'd4
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_WAIT_CLR,
      ST_SCAN_RD,
      ST_SCAN_EVAL,
      ST_SCAN_PEN,
      ST_W_INIT,
      ST_W_MUL1,
      ST_W_MUL2,
      ST_W_MUL3,
      ST_W_WR,
      ST_N_PREP,
      ST_N_RD,
      ST_N_CHK,
      ST_TARGET,
      ST_D_RD,
      ST_D_CHK,
      ST_FINISH
   } samp_state_type;

   typedef enum logic [1:0] {
      PN_IDLE,
      PN_NEG,
      PN_DIV,
      PN_SAT
   } pen_state_type;

   typedef struct packed {
      logic      start;
      logit_type value;
   } pen_req_type;

   typedef struct packed {
      logic      done;
      logit_type result;
   } pen_rsp_type;

   // 65536 * 2^(-j/16)
   function automatic logic [WGT_W-1:0] pow2_neg(input logic [4:0] j);
      logic [WGT_W-1:0] v;
      begin
         unique case (j)
            5'd0:  v = 17'd65536;
            5'd1:  v = 17'd62757;
            5'd2:  v = 17'd60097;
            5'd3:  v = 17'd57549;
            5'd4:  v = 17'd55109;
            5'd5:  v = 17'd52773;
            5'd6:  v = 17'd50535;
            5'd7:  v = 17'd48393;
            5'd8:  v = 17'd46341;
            5'd9:  v = 17'd44376;
            5'd10: v = 17'd42495;
            5'd11: v = 17'd40693;
            5'd12: v = 17'd38968;
            5'd13: v = 17'd37316;
            5'd14: v = 17'd35734;
            5'd15: v = 17'd34219;
            5'd16: v = 17'd32768;
            default: v = '0;
         endcase
         return v;
      end
   endfunction
endpackage
`default_nettype wire

// File: design/logit_top_k_top_p_sampler.sv
`timescale 1ns / 1ps
// channel  direction  bits                                       handshake
// req      in         tdata: logit[23:0] random_draw[47:24]      tvalid/tready
//                     tlast: last_logit, tuser: new_sequence
// rsp      out        tdata: token[10:0], tuser: stop_chosen[0]  tvalid/tready
//                     limit_reached[1]
// csr      in         index[2:0], wdata[16:0]                    we
//
// logits are taken one per cycle while idle and written to the logit memory.
// a draw scans the memory and sends each penalized logit to the penalty unit
// (a bit-serial divider for a positive one, a rounded product for a negative one),
// then computes a weight for each kept entry and walks the kept entries for the
// nucleus cut and the draw.
// after reset all 1026 history entries are cleared before req_tready rises;
// new_sequence starts the same pass, and a draw waits for it to end.
// a waiting result does not block new transfers on req.
`default_nettype none
`include "assert_macros.svh"
module logit_top_k_top_p_sampler (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // logit, random_draw
   input  logic        req_tlast,
   input  logic        req_tuser,   // new_sequence
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // token
   output logic [1:0]  rsp_tuser,   // stop_chosen, limit_reached
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [16:0] csr_wdata
);
   import lts_pkg::*;

   localparam int D_W  = LOGIT_WIDTH + 1;
   localparam int P1_W = D_W + TEMP_W;
   localparam int Y_W  = P1_W - 12;
   localparam int P2_W = Y_W + 16;
   localparam int T_W  = P2_W - 15;
   localparam int N_W  = T_W - 12;
   localparam int DM_W = 20;
   localparam int TH_W = TOPP_W + SUM_W;
   localparam int TG_W = DRAW_W + SUM_W;
   localparam int WE_W = IDX_W + WGT_W;

   // configuration
   logic [PEN_W-1:0]  penalty_ff;
   logic [TEMP_W-1:0] inv_temp_ff;
   logic [TOPK_W-1:0] top_k_ff;
   logic [TOPP_W-1:0] top_p_ff;
   logic [STEP_W-1:0] max_steps_ff;

   samp_state_type    state_ff, state_in;
   logic [IDX_W-1:0]  logit_index_ff, logit_index_in;
   logic [STEP_W-1:0] step_count_ff, step_count_in;
   logic              clr_active_ff, clr_active_in;
   logic [IDX_W-1:0]  clr_addr_ff, clr_addr_in;
   logic              init_ff, init_in;
   logic              over_ff, over_in;
   logic [KCNT_W-1:0] count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [DRAW_W-1:0] draw_ff, draw_in;
   logic [IDX_W-1:0]  scan_idx_ff, scan_idx_in;
   logit_type         best_val_ff [MAX_TOP_K];
   logic [IDX_W-1:0]  best_idx_ff [MAX_TOP_K];
   logit_type         max_ff, max_in;
   logic [IDX_W-1:0]  idx0_ff, idx0_in;
   logic [KCNT_W-1:0] j_ff, j_in;
   logic [P1_W-1:0]   prod1_ff, prod1_in;
   logic [P2_W-1:0]   prod2_ff, prod2_in;
   logic [WGT_W-1:0]  a_ff, a_in;
   logic [DM_W-1:0]   diffmul_ff, diffmul_in;
   logic [4:0]        shift_ff, shift_in;
   logic              zero_ff, zero_in;
   logic [SUM_W-1:0]  total_ff, total_in;
   logic [SUM_W-1:0]  cum_ff, cum_in;
   logic [TH_W-1:0]   thresh_ff, thresh_in;
   logic [KCNT_W-1:0] nucleus_ff, nucleus_in;
   logic [SUM_W-1:0]  nsum_ff, nsum_in;
   logic [SUM_W-1:0]  target_ff, target_in;
   logic [IDX_W-1:0]  token_ff, token_in;
   logic [IDX_W-1:0]  rsp_token_ff, rsp_token_in;
   logic              rsp_stop_ff, rsp_stop_in;
   logic              rsp_limit_ff, rsp_limit_in;

   logic              in_fire;
   logit_type         req_logit;
   logic [IDX_W-1:0]  idx_base;
   logic              logit_we;
   logit_type         logit_rd;
   logic              hist_rd;
   logic              hist_we;
   logic [IDX_W-1:0]  hist_waddr;
   logic              mark_we;
   logic [WE_W-1:0]   w_rd;
   logic              w_we;
   logic [STEP_W-1:0] limit_val;
   logic [STEP_W-1:0] step_inc;
   logic [KCNT_W-1:0] k_eff;
   logic [KCNT_W-1:0] j_next;
   logic              last_scan;
   logic              skip;
   logic              penal;
   logic              ins_en;
   logit_type         ins_val;
   logic              shift_en;
   logic              ge [MAX_TOP_K];
   logic [D_W-1:0]    diff;
   logic [Y_W-1:0]    y_val;
   logic [T_W-1:0]    t_val;
   logic [N_W-1:0]    n_val;
   logic [WGT_W-1:0]  tab_a;
   logic [WGT_W-1:0]  tab_b;
   logic [WGT_W-1:0]  interp;
   logic [WGT_W-1:0]  weight;
   logic [SUM_W-1:0]  cum_new;
   logic [TG_W-1:0]   target_prod;
   pen_req_type       pen_req;
   pen_rsp_type       pen_rsp;

   assign req_logit  = logit_type'(req_tdata[LOGIT_WIDTH-1:0]);
   assign req_tready = (state_ff == ST_IDLE) && !init_ff;
   assign in_fire    = req_tvalid && req_tready;
   assign idx_base   = req_tuser ? '0 : logit_index_ff;
   assign logit_we   = in_fire && (idx_base < IDX_W'(VOCAB_SIZE));

   lts_ram #(.WIDTH(LOGIT_WIDTH), .DEPTH(VOCAB_SIZE)) u_logit_ram (
      .clock   (clock),
      .wr_en   (logit_we),
      .wr_addr (idx_base),
      .wr_data (req_tdata[LOGIT_WIDTH-1:0]),
      .rd_addr (scan_idx_ff),
      .rd_data (logit_rd)
   );

   assign hist_we    = clr_active_ff || mark_we;
   assign hist_waddr = clr_active_ff ? clr_addr_ff : token_ff;

   lts_ram #(.WIDTH(1), .DEPTH(VOCAB_SIZE)) u_hist_ram (
      .clock   (clock),
      .wr_en   (hist_we),
      .wr_addr (hist_waddr),
      .wr_data (!clr_active_ff),
      .rd_addr (scan_idx_ff),
      .rd_data (hist_rd)
   );

   lts_ram #(.WIDTH(WE_W), .DEPTH(MAX_TOP_K)) u_weight_ram (
      .clock   (clock),
      .wr_en   (w_we),
      .wr_addr (j_ff[KPOS_W-1:0]),
      .wr_data ({best_idx_ff[0], weight}),
      .rd_addr (j_ff[KPOS_W-1:0]),
      .rd_data (w_rd)
   );

   lts_penalty u_penalty (
      .clock   (clock),
      .reset   (reset),
      .pen_req (pen_req),
      .penalty (penalty_ff),
      .pen_rsp (pen_rsp)
   );

   // insertion compare row
   always_comb begin
      for (int j = 0; j < MAX_TOP_K; j++) begin
         ge[j] = (KCNT_W'(j) < count_ff) && !(ins_val > best_val_ff[j]);
      end
   end

   // weight datapath
   always_comb begin
      diff   = D_W'({max_ff[LOGIT_WIDTH-1], max_ff}
                    - {best_val_ff[0][LOGIT_WIDTH-1], best_val_ff[0]});
      y_val  = prod1_ff[P1_W-1:12];
      t_val  = prod2_ff[P2_W-1:15];
      n_val  = t_val[T_W-1:12];
      tab_a  = pow2_neg({1'b0, t_val[11:8]});
      tab_b  = pow2_neg({1'b0, t_val[11:8]} + 5'd1);
      interp = a_ff - WGT_W'(diffmul_ff >> 8);
      weight = zero_ff ? '0 : (interp >> shift_ff);
   end

   always_comb begin
      limit_val = (max_steps_ff < STEP_W'(STEP_LIMIT)) ? max_steps_ff : STEP_W'(STEP_LIMIT);
      step_inc  = step_count_ff + STEP_W'(1);
      if (top_k_ff == '0) begin
         k_eff = KCNT_W'(1);
      end else if (top_k_ff > TOPK_W'(MAX_TOP_K)) begin
         k_eff = KCNT_W'(MAX_TOP_K);
      end else begin
         k_eff = KCNT_W'(top_k_ff);
      end
      j_next      = j_ff + KCNT_W'(1);
      last_scan   = scan_idx_ff == IDX_W'(VOCAB_SIZE - 1);
      skip        = (scan_idx_ff == ID_STOP) && (step_count_ff < STEP_W'(2));
      penal       = (scan_idx_ff == ID_FILLER) || (scan_idx_ff == ID_START) || hist_rd;
      cum_new     = cum_ff + SUM_W'(w_rd[WGT_W-1:0]);
      target_prod = TG_W'(draw_ff) * TG_W'(nsum_ff);
   end

   always_comb begin
      state_in       = state_ff;
      logit_index_in = logit_index_ff;
      step_count_in  = step_count_ff;
      clr_active_in  = clr_active_ff;
      clr_addr_in    = clr_addr_ff;
      init_in        = init_ff;
      over_in        = over_ff;
      count_in       = count_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      draw_in        = draw_ff;
      scan_idx_in    = scan_idx_ff;
      max_in         = max_ff;
      idx0_in        = idx0_ff;
      j_in           = j_ff;
      prod1_in       = prod1_ff;
      prod2_in       = prod2_ff;
      a_in           = a_ff;
      diffmul_in     = diffmul_ff;
      shift_in       = shift_ff;
      zero_in        = zero_ff;
      total_in       = total_ff;
      cum_in         = cum_ff;
      thresh_in      = thresh_ff;
      nucleus_in     = nucleus_ff;
      nsum_in        = nsum_ff;
      target_in      = target_ff;
      token_in       = token_ff;
      rsp_token_in   = rsp_token_ff;
      rsp_stop_in    = rsp_stop_ff;
      rsp_limit_in   = rsp_limit_ff;
      pen_req        = '{start: 1'b0, value: logit_rd};
      ins_en         = 1'b0;
      ins_val        = logit_rd;
      shift_en       = 1'b0;
      mark_we        = 1'b0;
      w_we           = 1'b0;

      // history clearing pass
      if (clr_active_ff) begin
         if (clr_addr_ff == IDX_W'(VOCAB_SIZE - 1)) begin
            clr_active_in = 1'b0;
            init_in       = 1'b0;
         end else begin
            clr_addr_in = clr_addr_ff + IDX_W'(1);
         end
      end

      if (in_fire) begin
         if (req_tuser) begin
            clr_active_in = 1'b1;
            clr_addr_in   = '0;
            step_count_in = '0;
         end
         if (idx_base < IDX_W'(VOCAB_SIZE)) begin
            logit_index_in = idx_base + IDX_W'(1);
         end else begin
            logit_index_in = idx_base;
         end
         if (req_tlast) begin
            logit_index_in = '0;
            draw_in        = req_tdata[LOGIT_WIDTH +: DRAW_W];
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (in_fire && req_tlast) begin
               state_in = ST_WAIT_CLR;
            end
         end
         ST_WAIT_CLR: begin
            if (!clr_active_ff) begin
               if (step_count_ff >= limit_val) begin
                  over_in  = 1'b1;
                  state_in = ST_FINISH;
               end else begin
                  scan_idx_in = '0;
                  count_in    = '0;
                  state_in    = ST_SCAN_RD;
               end
            end
         end
         ST_SCAN_RD: state_in = ST_SCAN_EVAL;
         ST_SCAN_EVAL: begin
            if (!skip && penal) begin
               pen_req.start = 1'b1;
               state_in      = ST_SCAN_PEN;
            end else begin
               ins_en = !skip;
               if (last_scan) begin
                  state_in = ST_W_INIT;
               end else begin
                  scan_idx_in = scan_idx_ff + IDX_W'(1);
                  state_in    = ST_SCAN_RD;
               end
            end
         end
         ST_SCAN_PEN: begin
            if (pen_rsp.done) begin
               ins_en  = 1'b1;
               ins_val = pen_rsp.result;
               if (last_scan) begin
                  state_in = ST_W_INIT;
               end else begin
                  scan_idx_in = scan_idx_ff + IDX_W'(1);
                  state_in    = ST_SCAN_RD;
               end
            end
         end
         ST_W_INIT: begin
            max_in   = best_val_ff[0];
            idx0_in  = best_idx_ff[0];
            j_in     = '0;
            total_in = '0;
            state_in = ST_W_MUL1;
         end
         ST_W_MUL1: begin
            prod1_in = P1_W'(diff) * P1_W'(inv_temp_ff);
            state_in = ST_W_MUL2;
         end
         ST_W_MUL2: begin
            prod2_in = P2_W'(y_val) * P2_W'(LOG2E_Q15);
            state_in = ST_W_MUL3;
         end
         ST_W_MUL3: begin
            zero_in    = n_val > N_W'(16);
            shift_in   = n_val[4:0];
            a_in       = tab_a;
            diffmul_in = DM_W'(12'(tab_a - tab_b)) * DM_W'(t_val[7:0]);
            state_in   = ST_W_WR;
         end
         ST_W_WR: begin
            w_we     = 1'b1;
            shift_en = 1'b1;
            total_in = total_ff + SUM_W'(weight);
            j_in     = j_next;
            state_in = (j_next == count_ff) ? ST_N_PREP : ST_W_MUL1;
         end
         ST_N_PREP: begin
            thresh_in = TH_W'(top_p_ff) * TH_W'(total_ff);
            j_in      = '0;
            cum_in    = '0;
            state_in  = ST_N_RD;
         end
         ST_N_RD: state_in = ST_N_CHK;
         ST_N_CHK: begin
            if ((TH_W'({cum_new, 16'b0}) >= thresh_ff) || (j_next == count_ff)) begin
               nucleus_in = j_next;
               nsum_in    = cum_new;
               state_in   = ST_TARGET;
            end else begin
               cum_in   = cum_new;
               j_in     = j_next;
               state_in = ST_N_RD;
            end
         end
         ST_TARGET: begin
            target_in = target_prod[TG_W-1:DRAW_W];
            j_in      = '0;
            cum_in    = '0;
            state_in  = ST_D_RD;
         end
         ST_D_RD: state_in = ST_D_CHK;
         ST_D_CHK: begin
            if (cum_new > target_ff) begin
               token_in = w_rd[WE_W-1:WGT_W];
               state_in = ST_FINISH;
            end else if (j_next == nucleus_ff) begin
               token_in = idx0_ff;
               state_in = ST_FINISH;
            end else begin
               cum_in   = cum_new;
               j_in     = j_next;
               state_in = ST_D_RD;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               over_in      = 1'b0;
               state_in     = ST_IDLE;
               priority if (over_ff) begin
                  rsp_token_in = '0;
                  rsp_stop_in  = 1'b0;
                  rsp_limit_in = 1'b1;
               end else if (token_ff == ID_STOP) begin
                  rsp_token_in = token_ff;
                  rsp_stop_in  = 1'b1;
                  rsp_limit_in = 1'b0;
               end else begin
                  mark_we       = 1'b1;
                  step_count_in = step_inc;
                  rsp_token_in  = token_ff;
                  rsp_stop_in   = 1'b0;
                  rsp_limit_in  = step_inc >= limit_val;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (ins_en && (count_ff < k_eff)) begin
         count_in = count_ff + KCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         penalty_ff     <= PEN_W'(4096);
         inv_temp_ff    <= TEMP_W'(4096);
         top_k_ff       <= TOPK_W'(64);
         top_p_ff       <= TOPP_W'(65536);
         max_steps_ff   <= STEP_W'(603);
         state_ff       <= ST_IDLE;
         logit_index_ff <= '0;
         step_count_ff  <= '0;
         clr_active_ff  <= 1'b1;
         clr_addr_ff    <= '0;
         init_ff        <= 1'b1;
         over_ff        <= 1'b0;
         count_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_PENALTY:   penalty_ff   <= csr_wdata[PEN_W-1:0];
               CSR_INV_TEMP:  inv_temp_ff  <= csr_wdata[TEMP_W-1:0];
               CSR_TOP_K:     top_k_ff     <= csr_wdata[TOPK_W-1:0];
               CSR_TOP_P:     top_p_ff     <= csr_wdata[TOPP_W-1:0];
               CSR_MAX_STEPS: max_steps_ff <= csr_wdata[STEP_W-1:0];
               default: ;
            endcase
         end
         state_ff       <= state_in;
         logit_index_ff <= logit_index_in;
         step_count_ff  <= step_count_in;
         clr_active_ff  <= clr_active_in;
         clr_addr_ff    <= clr_addr_in;
         init_ff        <= init_in;
         over_ff        <= over_in;
         count_ff       <= count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      draw_ff      <= draw_in;
      scan_idx_ff  <= scan_idx_in;
      max_ff       <= max_in;
      idx0_ff      <= idx0_in;
      j_ff         <= j_in;
      prod1_ff     <= prod1_in;
      prod2_ff     <= prod2_in;
      a_ff         <= a_in;
      diffmul_ff   <= diffmul_in;
      shift_ff     <= shift_in;
      zero_ff      <= zero_in;
      total_ff     <= total_in;
      cum_ff       <= cum_in;
      thresh_ff    <= thresh_in;
      nucleus_ff   <= nucleus_in;
      nsum_ff      <= nsum_in;
      target_ff    <= target_in;
      token_ff     <= token_in;
      rsp_token_ff <= rsp_token_in;
      rsp_stop_ff  <= rsp_stop_in;
      rsp_limit_ff <= rsp_limit_in;
   end

   // sorted top-k row: insert while scanning, shift toward the head while weighing
   always_ff @(posedge clock) begin
      if (ins_en) begin
         if ((KCNT_W'(0) < k_eff) && !ge[0]) begin
            best_val_ff[0] <= ins_val;
            best_idx_ff[0] <= scan_idx_ff;
         end
         for (int j = 1; j < MAX_TOP_K; j++) begin
            if ((KCNT_W'(j) < k_eff) && !ge[j]) begin
               if (ge[j-1]) begin
                  best_val_ff[j] <= ins_val;
                  best_idx_ff[j] <= scan_idx_ff;
               end else begin
                  best_val_ff[j] <= best_val_ff[j-1];
                  best_idx_ff[j] <= best_idx_ff[j-1];
               end
            end
         end
      end else if (shift_en) begin
         for (int j = 0; j < MAX_TOP_K - 1; j++) begin
            best_val_ff[j] <= best_val_ff[j+1];
            best_idx_ff[j] <= best_idx_ff[j+1];
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = 16'(rsp_token_ff);
   assign rsp_tuser  = {rsp_limit_ff, rsp_stop_ff};

   `ASSERT_NEVER(a_clr_scan, clock, reset, clr_active_ff && (state_ff == ST_SCAN_RD || state_ff == ST_SCAN_EVAL || state_ff == ST_SCAN_PEN), "history read during clearing")
   `ASSERT_NEVER(a_count_bound, clock, reset, count_ff > k_eff && state_ff == ST_SCAN_EVAL, "top-k row overfilled")
   `ASSERT_ALWAYS(a_nucleus_bound, clock, reset, (state_ff == ST_D_RD || state_ff == ST_D_CHK) |-> (nucleus_ff != '0 && nucleus_ff <= count_ff), "nucleus out of range")
   `ASSERT_ALWAYS(a_stop_no_count, clock, reset, (state_ff == ST_FINISH && token_ff == ID_STOP && !over_ff) |=> $stable(step_count_ff), "stop token counted")
endmodule
`default_nettype wire

// File: design/lts_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module lts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// File: design/lts_penalty.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module lts_penalty (
   input  logic                        clock,
   input  logic                        reset,
   input  lts_pkg::pen_req_type        pen_req,
   input  logic [lts_pkg::PEN_W-1:0]   penalty,
   output lts_pkg::pen_rsp_type        pen_rsp
);
   import lts_pkg::*;

   localparam int NUM_W  = LOGIT_WIDTH + 12;
   localparam int PROD_W = LOGIT_WIDTH + PEN_W;
   localparam int RND_W  = PROD_W - 12;
   localparam int CNT_W  = $clog2(NUM_W);
   localparam logic [RND_W-1:0] NEG_LIM = RND_W'(1) << (LOGIT_WIDTH - 1);
   localparam logic [NUM_W-1:0] POS_LIM = (NUM_W'(1) << (LOGIT_WIDTH - 1)) - NUM_W'(1);

   pen_state_type           pstate_ff, pstate_in;
   logic [NUM_W-1:0]        num_ff, num_in;
   logic [PEN_W-1:0]        rem_ff, rem_in;
   logic [PEN_W-1:0]        divisor_ff, divisor_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [PROD_W-1:0]       prod_ff, prod_in;
   logit_type               result_ff, result_in;
   logic                    done_ff, done_in;

   logic [PEN_W-1:0]        p_eff;
   logic [LOGIT_WIDTH-1:0]  mag;
   logic [PEN_W:0]          rem_sh;
   logic                    fits;
   logic [RND_W-1:0]        rounded;

   always_comb begin
      p_eff   = (penalty == '0) ? PEN_W'(1) : penalty;
      mag     = LOGIT_WIDTH'(-pen_req.value);
      rem_sh  = {rem_ff, num_ff[NUM_W-1]};
      fits    = rem_sh >= {1'b0, divisor_ff};
      rounded = RND_W'((prod_ff + PROD_W'(2048)) >> 12);

      pstate_in  = pstate_ff;
      num_in     = num_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      cnt_in     = cnt_ff;
      prod_in    = prod_ff;
      result_in  = result_ff;
      done_in    = 1'b0;

      unique case (pstate_ff)
         PN_IDLE: begin
            if (pen_req.start) begin
               if (pen_req.value < 0) begin
                  prod_in   = PROD_W'(mag) * PROD_W'(p_eff);
                  pstate_in = PN_NEG;
               end else begin
                  num_in     = NUM_W'({pen_req.value, 12'b0}) + NUM_W'(p_eff >> 1);
                  rem_in     = '0;
                  cnt_in     = '0;
                  divisor_in = p_eff;
                  pstate_in  = PN_DIV;
               end
            end
         end
         PN_NEG: begin
            result_in = (rounded > NEG_LIM) ? logit_type'(NEG_LIM)
                                            : logit_type'(-rounded);
            done_in   = 1'b1;
            pstate_in = PN_IDLE;
         end
         PN_DIV: begin
            rem_in = fits ? PEN_W'(rem_sh - {1'b0, divisor_ff}) : PEN_W'(rem_sh);
            num_in = {num_ff[NUM_W-2:0], fits};
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(NUM_W - 1)) begin
               pstate_in = PN_SAT;
            end
         end
         PN_SAT: begin
            result_in = (num_ff > POS_LIM) ? logit_type'(POS_LIM)
                                           : logit_type'(num_ff[LOGIT_WIDTH-1:0]);
            done_in   = 1'b1;
            pstate_in = PN_IDLE;
         end
         default: pstate_in = PN_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pstate_ff <= PN_IDLE;
         done_ff   <= 1'b0;
      end else begin
         pstate_ff <= pstate_in;
         done_ff   <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff     <= num_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      cnt_ff     <= cnt_in;
      prod_ff    <= prod_in;
      result_ff  <= result_in;
   end

   assign pen_rsp = '{done: done_ff, result: result_ff};

   `ASSERT_NEVER(a_start_busy, clock, reset, pen_req.start && pstate_ff != PN_IDLE, "start while busy")
   `ASSERT_ALWAYS(a_done_src, clock, reset, pen_rsp.done |-> ($past(pstate_ff) == PN_NEG || $past(pstate_ff) == PN_SAT), "done without result")
   `ASSERT_ALWAYS(a_rem_bound, clock, reset, pstate_ff == PN_DIV |-> rem_ff < divisor_ff, "remainder not below divisor")
endmodule
`default_nettype wire

// File: sim/logit_top_k_top_p_sampler_tb.sv
`timescale 1ns / 1ps
module logit_top_k_top_p_sampler_tb;
   import lts_pkg::*;

   localparam longint CYCLE_LIMIT = 6000000;
   localparam longint unsigned POW2_Q16 [17] = '{
      65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393, 46341,
      44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};

   typedef struct {
      logic [10:0] token;
      logic        stop;
      logic        lim;
   } draw_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;   // logit, random_draw
   logic        req_tlast = 1'b0;
   logic        req_tuser = 1'b0;  // new_sequence
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // token
   logic [1:0]  rsp_tuser;         // stop_chosen, limit_reached
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [16:0] csr_wdata = '0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   logit_top_k_top_p_sampler u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tlast(req_tlast), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // sampler state as seen from outside
   longint          logit_mem [VOCAB_SIZE];
   bit              history [VOCAB_SIZE];
   longint unsigned tokens_drawn, logit_pos;
   longint unsigned penalty, inv_temp, keep_k, nucleus_p, step_cap;
   draw_type        pending_draws [$];

   int     errors, n_items, n_draws, n_stops, n_limits;
   int     hold_cycles, rsp_gap;
   bit     idle_on = 1'b1;
   longint cycles;

   task automatic report(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
   endtask

   function automatic longint clamp_logit(longint x);
      if (x > 64'sd8388607) return 64'sd8388607;
      if (x < -64'sd8388608) return -64'sd8388608;
      return x;
   endfunction

   function automatic longint apply_penalty(longint v);
      longint unsigned p;
      longint unsigned mag;
      p = (penalty == 0) ? 1 : penalty;
      if (v < 0) begin
         mag = longint'(-v) * p;
         return clamp_logit(-longint'((mag + 2048) >> 12));
      end
      return clamp_logit(longint'(((longint'(v) << 12) + p / 2) / p));
   endfunction

   function automatic longint unsigned exp_weight(longint unsigned d);
      longint unsigned y, t, n, f, a, b;
      y = (d * inv_temp) >> 12;
      t = (y * 47274) >> 15;
      n = t >> 12;
      f = t & 4095;
      if (n > 16) return 0;
      a = POW2_Q16[f >> 8];
      b = POW2_Q16[(f >> 8) + 1];
      return (a - (((a - b) * (f & 255)) >> 8)) >> n;
   endfunction

   function automatic void predict_transfer(logic signed [23:0] lg, bit last, bit newseq,
                                            logic [23:0] rnd);
      longint          best_v [MAX_TOP_K];
      int              best_i [MAX_TOP_K];
      longint unsigned w [MAX_TOP_K];
      longint unsigned lim, k, cnt, total, cum, nuc, target;
      longint          val;
      int              j, tok;
      draw_type        d;
      if (newseq) begin
         history = '{default: 1'b0};
         tokens_drawn = 0;
         logit_pos = 0;
      end
      if (logit_pos < VOCAB_SIZE) begin
         logit_mem[logit_pos] = longint'(lg);
         logit_pos++;
      end
      if (!last) return;
      logit_pos = 0;
      lim = (step_cap < STEP_LIMIT) ? step_cap : STEP_LIMIT;
      if (tokens_drawn >= lim) begin
         d = '{11'd0, 1'b0, 1'b1};
         pending_draws = {pending_draws, d};
         return;
      end
      k = (keep_k < 1) ? 1 : keep_k;
      if (k > MAX_TOP_K) k = MAX_TOP_K;
      cnt = 0;
      for (int i = 0; i < VOCAB_SIZE; i++) begin
         val = logit_mem[i];
         if (i == ID_STOP && tokens_drawn < 2) continue;
         if (i == ID_FILLER || i == ID_START || history[i]) val = apply_penalty(val);
         if (cnt == k && !(val > best_v[k - 1])) continue;
         j = (cnt < k) ? cnt : k - 1;
         while (j > 0 && val > best_v[j - 1]) begin
            best_v[j] = best_v[j - 1];
            best_i[j] = best_i[j - 1];
            j--;
         end
         best_v[j] = val;
         best_i[j] = i;
         if (cnt < k) cnt++;
      end
      total = 0;
      for (int m = 0; m < cnt; m++) begin
         w[m] = exp_weight(longint'(best_v[0] - best_v[m]));
         total += w[m];
      end
      nuc = cnt;
      cum = 0;
      for (int m = 0; m < cnt; m++) begin
         cum += w[m];
         if (cum * 65536 >= nucleus_p * total) begin
            nuc = m + 1;
            break;
         end
      end
      total = 0;
      for (int m = 0; m < nuc; m++) total += w[m];
      target = (longint'(rnd) * total) >> 24;
      tok = best_i[0];
      cum = 0;
      for (int m = 0; m < nuc; m++) begin
         cum += w[m];
         if (cum > target) begin
            tok = best_i[m];
            break;
         end
      end
      if (tok == ID_STOP) begin
         d = '{11'(tok), 1'b1, 1'b0};
      end else begin
         history[tok] = 1'b1;
         tokens_drawn++;
         d = '{11'(tok), 1'b0, tokens_drawn >= lim};
      end
      pending_draws = {pending_draws, d};
   endfunction

   task automatic send_logit(logic signed [23:0] lg, bit last, bit newseq, logic [23:0] rnd);
      int gap;
      gap = idle_on ? $urandom_range(0, 4) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = {rnd, lg};
      req_tlast = last;
      req_tuser = newseq;
      do @(posedge clock); while (!req_tready);
      predict_transfer(lg, last, newseq, rnd);
      n_items++;
   endtask

   function automatic logic signed [23:0] rand_logit(bit wide);
      if (wide) return 24'($urandom());
      return 24'($signed($urandom_range(0, 32767)) - 16384);
   endfunction

   task automatic send_step(int n, bit newseq, bit wide);
      for (int i = 0; i < n; i++)
         send_logit(rand_logit(wide), i == n - 1, newseq && i == 0, 24'($urandom()));
   endtask

   // writes every vocabulary entry plus two extra logits that must be dropped
   task automatic send_full_step(bit newseq, bit set_stop, logic signed [23:0] stop_logit);
      logic signed [23:0] lg;
      for (int i = 0; i < VOCAB_SIZE + 2; i++) begin
         lg = (set_stop && i == ID_STOP) ? stop_logit : rand_logit($urandom_range(0, 9) == 0);
         send_logit(lg, i == VOCAB_SIZE + 1, newseq && i == 0, 24'($urandom()));
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_draws.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [16:0] value);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      case (idx)
         CSR_PENALTY:   penalty = value & 17'hFFFF;
         CSR_INV_TEMP:  inv_temp = value & 17'hFFFF;
         CSR_TOP_K:     keep_k = value & 17'h7F;
         CSR_TOP_P:     nucleus_p = value;
         CSR_MAX_STEPS: step_cap = value & 17'h3FF;
         default: ;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // result checker
   always @(posedge clock) begin
      draw_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_draws.size() == 0) begin
            report("unexpected result token", rsp_tdata, -1);
         end else begin
            want = pending_draws.pop_front();
            n_draws++;
            if (want.stop) n_stops++;
            if (want.lim) n_limits++;
            if (rsp_tdata !== {5'd0, want.token}) report("token", rsp_tdata, want.token);
            if (rsp_tuser[0] !== want.stop) report("stop_chosen", rsp_tuser[0], want.stop);
            if (rsp_tuser[1] !== want.lim) report("limit_reached", rsp_tuser[1], want.lim);
         end
         rsp_gap = idle_on ? $urandom_range(0, 4) : 0;
      end
   end

   // receiver ready, with a long hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_tready = 1'b0;
            hold_cycles--;
         end else if (rsp_gap > 0) begin
            rsp_tready = 1'b0;
            rsp_gap--;
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("logit_top_k_top_p_sampler_tb: errors");
         $finish;
      end
   end

   // the full fill also places a strong stop logit for the stop test
   task automatic test_first_fill();
      send_full_step(1'b1, 1'b1, 24'sh200000);
      wait_drained();
   endtask

   task automatic test_field_extremes();
      send_logit(24'sh7FFFFF, 1'b0, 1'b0, 24'h000000);
      send_logit(-24'sh800000, 1'b0, 1'b0, 24'hFFFFFF);
      send_logit(24'sh000000, 1'b1, 1'b0, 24'h000000);
      send_logit(-24'sh800000, 1'b0, 1'b0, 24'h000000);
      send_logit(24'sh7FFFFF, 1'b1, 1'b0, 24'hFFFFFF);
      wait_drained();
   endtask

   task automatic test_register_extremes();
      write_reg(CSR_PENALTY, 17'd0);
      write_reg(CSR_INV_TEMP, 17'd0);
      write_reg(CSR_TOP_K, 17'd0);
      write_reg(CSR_TOP_P, 17'd0);
      send_step(3, 1'b0, 1'b0);
      wait_drained();
      write_reg(CSR_PENALTY, 17'd65535);
      write_reg(CSR_INV_TEMP, 17'd65535);
      write_reg(CSR_TOP_K, 17'd127);
      write_reg(CSR_TOP_P, 17'h1FFFF);
      send_step(3, 1'b0, 1'b1);
      wait_drained();
      write_reg(CSR_INV_TEMP, 17'd1);
      write_reg(CSR_TOP_P, 17'd65536);
      write_reg(CSR_PENALTY, 17'd1);
      send_step(2, 1'b0, 1'b1);
      wait_drained();
   endtask

   task automatic test_step_limit();
      write_reg(CSR_MAX_STEPS, 17'd0);
      send_step(2, 1'b1, 1'b0);
      wait_drained();
      write_reg(CSR_MAX_STEPS, 17'd2);
      for (int s = 0; s < 3; s++) send_step(1, s == 0, 1'b0);
      wait_drained();
      write_reg(CSR_MAX_STEPS, 17'd1023);
      write_reg(CSR_PENALTY, 17'd4096);
      write_reg(CSR_INV_TEMP, 17'd4096);
      wait_drained();
   endtask

   task automatic test_stop_token();
      write_reg(CSR_TOP_K, 17'd1);
      send_step(1, 1'b1, 1'b0);
      send_step(1, 1'b0, 1'b0);
      send_step(1, 1'b0, 1'b0);
      wait_drained();
      write_reg(CSR_TOP_K, 17'd64);
   endtask

   task automatic test_random_steps(int n_steps);
      csr_index_type idx;
      logic [16:0]   value;
      for (int s = 0; s < n_steps; s++) begin
         if (s % 10 == 0) begin
            wait_drained();
            idle_on = ($urandom_range(0, 3) != 0);
            repeat (2) begin
               idx = csr_index_type'($urandom_range(0, 4));
               case (idx)
                  CSR_PENALTY:  value = $urandom_range(0, 3) == 0 ? 17'($urandom_range(0, 65535))
                                                              : 17'($urandom_range(3000, 6000));
                  CSR_INV_TEMP: value = 17'($urandom_range(0, 65535));
                  CSR_TOP_K:    value = 17'($urandom_range(0, 127));
                  CSR_TOP_P:    value = 17'($urandom_range(0, 131071));
                  default:      value = $urandom_range(0, 2) == 0 ? 17'd1023
                                                              : 17'($urandom_range(0, 12));
               endcase
               write_reg(idx, value);
            end
         end
         send_step($urandom_range(1, 8), $urandom_range(0, 5) == 0, $urandom_range(0, 3) == 0);
      end
      wait_drained();
      idle_on = 1'b1;
   endtask

   task automatic test_result_backpressure();
      write_reg(CSR_MAX_STEPS, 17'd603);
      hold_cycles = 9000;
      for (int s = 0; s < 5; s++) send_step($urandom_range(1, 4), s == 0, 1'b0);
      wait_drained();
   endtask

   initial begin
      penalty = 4096;
      inv_temp = 4096;
      keep_k = 64;
      nucleus_p = 65536;
      step_cap = 603;
      history = '{default: 1'b0};
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_first_fill();
      test_field_extremes();
      test_register_extremes();
      test_step_limit();
      test_stop_token();
      test_random_steps(24);
      test_result_backpressure();

      while (pending_draws.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      errors += pending_draws.size();
      $display("covered %0d logit transfers and %0d draws (%0d stop, %0d at step limit)",
               n_items, n_draws, n_stops, n_limits);
      $display("register extremes, full and short steps, and a long result stall included");
      if (errors == 0) begin
         $display("logit_top_k_top_p_sampler_tb: clean");
      end else begin
         $display("logit_top_k_top_p_sampler_tb: errors");
      end
      $finish;
   end
endmodule

// File: files.f
+incdir+design
design/lts_pkg.sv
design/lts_ram.sv
design/lts_penalty.sv
design/logit_top_k_top_p_sampler.sv
sim/logit_top_k_top_p_sampler_tb.sv
